// ===== src/contour_cell_segment_linker_core_defines.svh =====
// assertion macros for the contour cell segment linker
`ifndef CONTOUR_CELL_SEGMENT_LINKER_CORE_DEFINES_SVH
`define CONTOUR_CELL_SEGMENT_LINKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define CSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("contour linker check failed");
// expression must never be true outside reset
`define CSL_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("contour linker forbidden condition");
`else
`define CSL_ASSERT(lbl, prop)
`define CSL_NEVER(lbl, expr)
`endif
`endif

// ===== src/cslink_pkg.sv =====
package cslink_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_D     = 3'd4;

  // output beat widths
  localparam int OUT_W  = 40;
  localparam int USER_W = 2;
  localparam int Q_W    = 6;

  // corner offsets, bit i for corner ll, lr, ur, ul
  localparam logic [3:0] COL_OFF = 4'b0110;
  localparam logic [3:0] ROW_OFF = 4'b1100;

  // triangle case codes
  localparam logic [3:0] CASE_NONE = 4'd0;

  // case from the signs of (corner, centre, next corner)
  localparam logic [3:0] SIGN_CASE [27] = '{
    4'd0, 4'd0, 4'd8, 4'd0, 4'd2, 4'd5, 4'd7, 4'd6, 4'd9,
    4'd0, 4'd3, 4'd4, 4'd1, 4'd3, 4'd1, 4'd4, 4'd3, 4'd0,
    4'd9, 4'd6, 4'd7, 4'd5, 4'd2, 4'd0, 4'd8, 4'd0, 4'd0
  };

  // end point roles, equal pair is a vertex, else a side
  typedef struct packed {
    logic [1:0] a1;
    logic [1:0] b1;
    logic [1:0] a2;
    logic [1:0] b2;
  } ends_t;

  localparam ends_t CASE_ENDS [10] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd2, 2'd2},
    '{2'd2, 2'd2, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd0, 2'd1}
  };

  // divider lane control
  typedef struct packed {
    logic           start;
    logic           direct;
    logic [Q_W-1:0] direct_val;
  } div_ctl_t;

  // one link record
  typedef struct packed {
    logic [1:0] level;
    logic [5:0] ocol;
    logic [5:0] orow;
    logic [5:0] hcol;
    logic [5:0] hrow;
    logic [5:0] tcol;
    logic [5:0] trow;
    logic       oslot;
    logic       islot;
  } seg_rec_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TRI,
    ST_PREP,
    ST_DIV,
    ST_PICK,
    ST_COMMIT,
    ST_FLUSH
  } state_t;

  // sign class: 0 negative, 1 zero, 2 positive
  function automatic logic [3:0] case_lookup(input logic [1:0] s0, input logic [1:0] s1,
                                             input logic [1:0] s2);
    logic [4:0] ix;
    ix = 5'(s0) * 5'd9 + 5'(s1) * 5'd3 + 5'(s2);
    return SIGN_CASE[ix];
  endfunction

endpackage

// ===== src/cslink_bitmap.sv =====
module cslink_bitmap #(
  parameter int DEPTH = 16384,
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cslink_divider.sv =====
module cslink_divider #(
  parameter int NW = 29,
  parameter int DW = 22
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cslink_pkg::div_ctl_t        ctl,
  input  logic [NW-1:0]               num,
  input  logic [DW-1:0]               den,
  output logic [cslink_pkg::Q_W-1:0]  q,
  output logic                        done
);
  import cslink_pkg::*;

  localparam int SW = DW + Q_W - 1;
  localparam int CNT_W = $clog2(Q_W);

  logic [NW-1:0]    rem;
  logic [SW-1:0]    dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             skip;
  logic             fits;

  assign fits = rem >= NW'(dsh);
  assign done = !busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(Q_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle while busy, restoring; none in direct mode
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= num;
      dsh  <= {den, {(Q_W-1){1'b0}}};
      skip <= ctl.direct;
      q    <= ctl.direct ? ctl.direct_val : '0;
    end else if (busy && !skip) begin
      if (fits) begin
        rem <= rem - NW'(dsh);
      end
      q   <= {q[Q_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

endmodule

// ===== src/contour_cell_segment_linker_core.sv =====
// flow: a segment passes setup, prep, divide, map read and commit, a skipped triangle
// setup alone; a beat is held until the next segment commits or the cell ends
// throughput: one cell at a time; the time per cell is set by the six-step crossing
// dividers and the occupancy map updates, plus receiver stalls
// reset: synchronous; then both maps are swept to empty, one entry per cycle (16384)
`include "contour_cell_segment_linker_core_defines.svh"
module contour_cell_segment_linker_core #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int LEVELS = 4,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W = ((36 + 4 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // cell_col, cell_row, corner_ll, corner_lr, corner_ur, corner_ul,
  // x_left, x_right, y_bottom, y_top
  input  logic [IN_W-1:0]                      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // origin_col, origin_row, head_col, head_row, tail_col, tail_row,
  // out_second_slot, in_second_slot
  output logic [cslink_pkg::OUT_W-1:0]         m_tdata,
  // level_index
  output logic [cslink_pkg::USER_W-1:0]        m_tuser,
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cslink_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]               cfg_data
);
  import cslink_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int HW = SB + 4;
  localparam int NW = HW + 9;
  localparam int DW = HW + 2;
  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int MAP_SIZE = LEVELS * GRID_COLS * GRID_ROWS;
  localparam int AW = $clog2(MAP_SIZE);

  typedef logic [CW-1:0] cwrap_t [64];
  typedef logic [RW-1:0] rwrap_t [64];

  function automatic cwrap_t col_table();
    cwrap_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = CW'(i % GRID_COLS);
    end
    return t;
  endfunction

  function automatic rwrap_t row_table();
    rwrap_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = RW'(i % GRID_ROWS);
    end
    return t;
  endfunction

  localparam cwrap_t COL_WRAP = col_table();
  localparam rwrap_t ROW_WRAP = row_table();

  function automatic logic [AW-1:0] map_addr(input logic [1:0] k, input logic [5:0] c,
                                             input logic [5:0] r);
    return AW'(k) * AW'(GRID_COLS * GRID_ROWS) + AW'(COL_WRAP[c]) * AW'(GRID_ROWS)
           + AW'(ROW_WRAP[r]);
  endfunction

  function automatic logic [1:0] sign_class(input logic signed [HW-1:0] h);
    if (h > 0) begin
      return 2'd2;
    end else if (h < 0) begin
      return 2'd0;
    end
    return 2'd1;
  endfunction

  state_t state, state_next;

  // configuration
  logic [2:0]           level_count;
  logic signed [SB-1:0] lv [4];

  // cell registers
  logic [5:0]             cell_col, cell_row;
  logic signed [SB-1:0]   d [4];
  logic [5:0]             xs [2];
  logic [5:0]             ys [2];
  logic signed [SB-1:0]   dmin, dmax;
  logic signed [SB+1:0]   dsum;

  // sequencing
  logic [1:0]    lvl, tri_idx;
  logic [AW-1:0] clr_addr;

  // triangle registers
  logic signed [HW-1:0] hh [3];
  logic [7:0]           xx [3];
  logic [7:0]           yy [3];
  ends_t                ends;

  // pick registers
  logic [5:0]    hx, hy, tx, ty;
  logic [AW-1:0] o_addr, i_addr;

  // pending and output records
  seg_rec_t pend, obuf;
  logic     pend_valid, obuf_last;

  // strobes
  logic accept, rd_en, commit, flush_move, adv, cell_end, out_free;
  logic skip_cell, tri_skip, degen, div_done;

  // unpacked input beat
  logic [5:0]           in_col, in_row;
  logic signed [SB-1:0] in_d [4];
  logic [5:0]           in_x [2];
  logic [5:0]           in_y [2];
  logic signed [SB-1:0] in_min, in_max;

  always_comb begin
    in_col = s_tdata[5:0];
    in_row = s_tdata[11:6];
    for (int i = 0; i < 4; i++) begin
      in_d[i] = $signed(s_tdata[12 + i*SB +: SB]);
    end
    in_x[0] = s_tdata[12 + 4*SB +: 6];
    in_x[1] = s_tdata[18 + 4*SB +: 6];
    in_y[0] = s_tdata[24 + 4*SB +: 6];
    in_y[1] = s_tdata[30 + 4*SB +: 6];
    in_min = in_d[0];
    in_max = in_d[0];
    for (int i = 1; i < 4; i++) begin
      if (in_d[i] < in_min) in_min = in_d[i];
      if (in_d[i] > in_max) in_max = in_d[i];
    end
  end

  // level count saturation
  logic [2:0] ncount;
  logic [1:0] last_lvl;
  assign ncount = (level_count > 3'(LEVELS)) ? 3'(LEVELS) : level_count;
  assign last_lvl = 2'(ncount - 3'd1);

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 3'd1;
      for (int i = 0; i < 4; i++) lv[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEVEL_COUNT: level_count <= cfg_data[2:0];
        REG_LEVEL_A:     lv[0] <= $signed(cfg_data);
        REG_LEVEL_B:     lv[1] <= $signed(cfg_data);
        REG_LEVEL_C:     lv[2] <= $signed(cfg_data);
        REG_LEVEL_D:     lv[3] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // cell capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_col <= in_col;
      cell_row <= in_row;
      for (int i = 0; i < 4; i++) d[i] <= in_d[i];
      xs <= in_x;
      ys <= in_y;
      dmin <= in_min;
      dmax <= in_max;
      dsum <= (SB+2)'(in_d[0]) + (SB+2)'(in_d[1]) + (SB+2)'(in_d[2]) + (SB+2)'(in_d[3]);
    end
  end

  assign skip_cell = (ncount == 3'd0) || (dmax < lv[0]) || (dmin > lv[last_lvl]);

  // triangle setup: quarter-unit levels and half-unit coordinates
  logic signed [SB:0]   diff [4];
  logic signed [HW-1:0] hc [4];
  logic signed [HW-1:0] h0;
  logic [1:0]           c0, c2;
  logic [3:0]           cs;
  logic                 lvl_in;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i] = (SB+1)'(d[i]) - (SB+1)'(lv[lvl]);
      hc[i] = {diff[i][SB], diff[i], 2'b00};
    end
    h0 = {{2{dsum[SB+1]}}, dsum} - {{2{lv[lvl][SB-1]}}, lv[lvl], 2'b00};
    c0 = tri_idx;
    c2 = tri_idx + 2'd1;
    lvl_in = !((lv[lvl] < dmin) || (lv[lvl] > dmax));
    cs = case_lookup(sign_class(hc[c0]), sign_class(h0), sign_class(hc[c2]));
  end

  assign tri_skip = !lvl_in || (cs == CASE_NONE);

  always_ff @(posedge clk) begin
    if (state == ST_TRI) begin
      hh[0] <= hc[c0];
      hh[1] <= h0;
      hh[2] <= hc[c2];
      xx[0] <= {1'b0, xs[COL_OFF[c0]], 1'b0};
      xx[1] <= {2'b00, xs[0]} + {2'b00, xs[1]};
      xx[2] <= {1'b0, xs[COL_OFF[c2]], 1'b0};
      yy[0] <= {1'b0, ys[ROW_OFF[c0]], 1'b0};
      yy[1] <= {2'b00, ys[0]} + {2'b00, ys[1]};
      yy[2] <= {1'b0, ys[ROW_OFF[c2]], 1'b0};
      ends  <= CASE_ENDS[cs];
    end
  end

  // crossing numerators and denominators, lanes x1, y1, x2, y2
  div_ctl_t             ctl [4];
  logic [NW-1:0]        num_abs [4];
  logic [DW-1:0]        den_abs [4];
  logic [Q_W-1:0]       q [4];
  logic [3:0]           lane_done;

  always_comb begin
    logic [1:0]           a, b;
    logic [7:0]           ca, cb;
    logic signed [HW:0]   hd;
    logic signed [DW-1:0] den_s;
    logic signed [NW-1:0] p1, p2, num_s;
    for (int l = 0; l < 4; l++) begin
      a = (l < 2) ? ends.a1 : ends.a2;
      b = (l < 2) ? ends.b1 : ends.b2;
      ca = l[0] ? yy[a] : xx[a];
      cb = l[0] ? yy[b] : xx[b];
      hd = (HW+1)'(hh[b]) - (HW+1)'(hh[a]);
      den_s = {hd, 1'b0};
      p1 = hh[b] * $signed({1'b0, ca});
      p2 = hh[a] * $signed({1'b0, cb});
      num_s = p1 - p2;
      num_abs[l] = (den_s < 0) ? NW'(-num_s) : NW'(num_s);
      den_abs[l] = (den_s < 0) ? DW'(-den_s) : DW'(den_s);
      ctl[l].start = (state == ST_PREP);
      ctl[l].direct = (a == b) || (den_s == 0);
      ctl[l].direct_val = ca[6:1];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    cslink_divider #(.NW(NW), .DW(DW)) u_div (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[l]),
      .num  (num_abs[l]),
      .den  (den_abs[l]),
      .q    (q[l]),
      .done (lane_done[l])
    );
  end

  assign div_done = &lane_done;

  // head and tail choice
  logic [5:0] px1, py1, px2, py2;
  logic       head_first;
  assign px1 = q[0];
  assign py1 = q[1];
  assign px2 = q[2];
  assign py2 = q[3];
  assign degen = (px1 == px2) && (py1 == py2);
  assign head_first = (cell_col != px1) || (cell_row != py1);

  logic [5:0]    nhx, nhy;
  logic [AW-1:0] n_oaddr, n_iaddr;
  assign nhx = head_first ? px1 : px2;
  assign nhy = head_first ? py1 : py2;
  assign n_oaddr = map_addr(lvl, cell_col, cell_row);
  assign n_iaddr = map_addr(lvl, nhx, nhy);

  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      hx <= nhx;
      hy <= nhy;
      tx <= head_first ? px2 : px1;
      ty <= head_first ? py2 : py1;
      o_addr <= n_oaddr;
      i_addr <= n_iaddr;
    end
  end

  // occupancy maps
  logic          clearing, o_rd, i_rd, map_wr;
  logic [AW-1:0] o_wr_addr, i_wr_addr;
  assign clearing = (state == ST_CLEAR);
  assign map_wr = clearing || commit;
  assign o_wr_addr = clearing ? clr_addr : o_addr;
  assign i_wr_addr = clearing ? clr_addr : i_addr;

  cslink_bitmap #(.DEPTH(MAP_SIZE), .AW(AW)) u_out_map (
    .clk     (clk),
    .wr_en   (map_wr),
    .wr_addr (o_wr_addr),
    .wr_bit  (!clearing),
    .rd_en   (rd_en),
    .rd_addr (n_oaddr),
    .rd_bit  (o_rd)
  );

  cslink_bitmap #(.DEPTH(MAP_SIZE), .AW(AW)) u_in_map (
    .clk     (clk),
    .wr_en   (map_wr),
    .wr_addr (i_wr_addr),
    .wr_bit  (!clearing),
    .rd_en   (rd_en),
    .rd_addr (n_iaddr),
    .rd_bit  (i_rd)
  );

  // strobes
  assign out_free = !m_tvalid || m_tready;
  assign cell_end = (tri_idx == 2'd3) && (lvl == last_lvl);

  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    flush_move = 1'b0;
    adv        = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_TRI:    adv = tri_skip;
      ST_PICK: begin
        rd_en = !degen;
        adv = degen;
      end
      ST_COMMIT: begin
        commit = !pend_valid || out_free;
        adv = commit;
      end
      ST_FLUSH:  flush_move = pend_valid && out_free;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == AW'(MAP_SIZE - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_CHECK;
      ST_CHECK:  state_next = skip_cell ? ST_IDLE : ST_TRI;
      ST_TRI: begin
        if (!tri_skip) state_next = ST_PREP;
        else if (cell_end) state_next = ST_FLUSH;
      end
      ST_PREP:   state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_PICK;
      ST_PICK: begin
        if (!degen) state_next = ST_COMMIT;
        else state_next = cell_end ? ST_FLUSH : ST_TRI;
      end
      ST_COMMIT: if (commit) state_next = cell_end ? ST_FLUSH : ST_TRI;
      ST_FLUSH:  if (!pend_valid || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
    end
  end

  // level and triangle counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
      tri_idx <= '0;
    end else if (accept) begin
      lvl <= '0;
      tri_idx <= '0;
    end else if (adv) begin
      tri_idx <= tri_idx + 2'd1;
      if (tri_idx == 2'd3) lvl <= lvl + 2'd1;
    end
  end

  // pending record and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if ((commit && pend_valid) || flush_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (commit) begin
        pend_valid <= 1'b1;
      end else if (flush_move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pend.level <= lvl;
      pend.ocol  <= cell_col;
      pend.orow  <= cell_row;
      pend.hcol  <= hx;
      pend.hrow  <= hy;
      pend.tcol  <= tx;
      pend.trow  <= ty;
      pend.oslot <= o_rd;
      pend.islot <= i_rd;
    end
    if ((commit && pend_valid) || flush_move) begin
      obuf <= pend;
      obuf_last <= flush_move;
    end
  end

  assign m_tdata = {2'b00, obuf.islot, obuf.oslot, obuf.trow, obuf.tcol, obuf.hrow,
                    obuf.hcol, obuf.orow, obuf.ocol};
  assign m_tuser = obuf.level;
  assign m_tlast = obuf_last;

  `CSL_ASSERT(a_no_accept_in_clear, (state == ST_CLEAR) |-> !s_tready)
  `CSL_ASSERT(a_idle_no_pending, (state == ST_IDLE) |-> !pend_valid)
  `CSL_ASSERT(a_accept_to_check, accept |=> (state == ST_CHECK))
  `CSL_ASSERT(a_commit_after_read, commit |-> ($past(rd_en) || $past(state) == ST_COMMIT))
  `CSL_NEVER(a_map_write_scope, map_wr && !(state == ST_CLEAR || state == ST_COMMIT))

endmodule

// ===== bench/tb_contour_cell_segment_linker_core.sv =====
`default_nettype none
module tb_contour_cell_segment_linker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cslink_pkg::*;

  localparam int IN_W = 104;
  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE = 250;

  // one grid cell as it enters the block
  typedef struct {
    logic [5:0] col;
    logic [5:0] row;
    logic signed [15:0] crn [4];
    logic [5:0] xl, xr, yb, yt;
    bit no_link;
  } cell_t;

  // one link beat as it leaves the block
  typedef struct {
    logic [1:0] level;
    logic [5:0] ocol, orow, hcol, hrow, tcol, trow;
    logic oslot, islot, last;
  } link_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [USER_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  contour_cell_segment_linker_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of configuration and occupancy maps
  logic [2:0] lvl_count = 3'd1;
  logic signed [15:0] lvl [4] = '{default: 16'sd0};
  bit out_taken [16384];
  bit in_taken [16384];

  link_t link_q [$];
  int errors = 0;
  int cells_sent = 0;
  int links_seen = 0;
  int cfg_sets = 0;
  bit calm = 1'b0;

  // triangle case from signs (0 neg, 1 zero, 2 pos) of corner, centre, next
  int tri_case [27] = '{0, 0, 8, 0, 2, 5, 7, 6, 9,
                        0, 3, 4, 1, 3, 1, 4, 3, 0,
                        9, 6, 7, 5, 2, 0, 8, 0, 0};
  int tri_ends [10][4] = '{'{0,0,0,0}, '{0,0,1,1}, '{1,1,2,2}, '{2,2,0,0},
                           '{0,0,1,2}, '{1,1,2,0}, '{2,2,0,1},
                           '{0,1,1,2}, '{1,2,2,0}, '{2,0,0,1}};

  // end point on a vertex or an exact truncated crossing on a side
  function automatic longint end_pt(longint h[3], longint c[3], int a, int b);
    longint num, den;
    if (a == b) return c[a] / 2;
    den = 2 * (h[b] - h[a]);
    if (den == 0) return c[a] / 2;
    num = h[b] * c[a] - h[a] * c[b];
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return num / den;
  endfunction

  // work out the link beats of one cell and queue them
  function automatic int predict_links(cell_t c);
    longint d [4];
    longint lv [4];
    longint h [5], cx [5], cy [5];
    longint hh [3], xx [3], yy [3];
    longint dmin, dmax, x1, y1, x2, y2, hx, hy, tx, ty;
    int sg [5];
    int nlev, n, cs, r0, r2, oi, ii;
    link_t rec;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      d[i] = c.crn[i];
      lv[i] = lvl[i];
    end
    nlev = (lvl_count > 3'd4) ? 4 : int'(lvl_count);
    if (nlev == 0) return 0;
    dmin = d[0];
    dmax = d[0];
    for (int i = 1; i < 4; i++) begin
      if (d[i] < dmin) dmin = d[i];
      if (d[i] > dmax) dmax = d[i];
    end
    if (dmax < lv[0] || dmin > lv[nlev-1]) return 0;
    for (int k = 0; k < nlev; k++) begin
      if (lv[k] < dmin || lv[k] > dmax) continue;
      h[0] = 0;
      for (int m = 1; m <= 4; m++) begin
        h[m] = 4 * (d[m-1] - lv[k]);
        h[0] += d[m-1] - lv[k];
        cx[m] = 2 * ((m == 2 || m == 3) ? longint'(c.xr) : longint'(c.xl));
        cy[m] = 2 * ((m >= 3) ? longint'(c.yt) : longint'(c.yb));
      end
      cx[0] = longint'(c.xl) + longint'(c.xr);
      cy[0] = longint'(c.yb) + longint'(c.yt);
      for (int m = 0; m <= 4; m++) sg[m] = (h[m] > 0) ? 2 : ((h[m] < 0) ? 0 : 1);
      for (int m = 1; m <= 4; m++) begin
        r0 = m;
        r2 = (m != 4) ? m + 1 : 1;
        cs = tri_case[sg[r0] * 9 + sg[0] * 3 + sg[r2]];
        if (cs == 0) continue;
        hh = '{h[r0], h[0], h[r2]};
        xx = '{cx[r0], cx[0], cx[r2]};
        yy = '{cy[r0], cy[0], cy[r2]};
        x1 = end_pt(hh, xx, tri_ends[cs][0], tri_ends[cs][1]);
        y1 = end_pt(hh, yy, tri_ends[cs][0], tri_ends[cs][1]);
        x2 = end_pt(hh, xx, tri_ends[cs][2], tri_ends[cs][3]);
        y2 = end_pt(hh, yy, tri_ends[cs][2], tri_ends[cs][3]);
        if (x1 == x2 && y1 == y2) continue;
        if (longint'(c.col) != x1 || longint'(c.row) != y1) begin
          hx = x1; hy = y1; tx = x2; ty = y2;
        end else begin
          hx = x2; hy = y2; tx = x1; ty = y1;
        end
        if (n >= 16) continue;
        oi = k * 4096 + int'(c.col) * 64 + int'(c.row);
        ii = k * 4096 + int'(hx & 63) * 64 + int'(hy & 63);
        rec.level = k[1:0];
        rec.ocol = c.col;
        rec.orow = c.row;
        rec.hcol = hx[5:0];
        rec.hrow = hy[5:0];
        rec.tcol = tx[5:0];
        rec.trow = ty[5:0];
        rec.oslot = out_taken[oi];
        out_taken[oi] = 1'b1;
        rec.islot = in_taken[ii];
        in_taken[ii] = 1'b1;
        rec.last = 1'b0;
        link_q.push_back(rec);
        n++;
      end
    end
    if (n > 0) link_q[link_q.size()-1].last = 1'b1;
    return n;
  endfunction

  // directed cell builder
  function automatic cell_t mk(int col, int row, int ll, int lr, int ur, int ul,
                               int xl, int xr, int yb, int yt, bit none);
    cell_t c;
    c.col = col[5:0]; c.row = row[5:0];
    c.crn = '{ll[15:0], lr[15:0], ur[15:0], ul[15:0]};
    c.xl = xl[5:0]; c.xr = xr[5:0]; c.yb = yb[5:0]; c.yt = yt[5:0];
    c.no_link = none;
    return c;
  endfunction

  function automatic logic signed [15:0] near_level();
    int v;
    v = int'(lvl[2'($urandom_range(0, 3))]);
    if ($urandom_range(0, 5) != 0) v += int'($urandom_range(0, 600)) - 300;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // mostly well formed cells, often on a small patch, some pure noise
  function automatic cell_t rand_cell();
    cell_t c;
    int col, row;
    c.no_link = 1'b0;
    if ($urandom_range(0, 4) == 0) begin
      c.col = 6'($urandom()); c.row = 6'($urandom());
      for (int i = 0; i < 4; i++) c.crn[i] = 16'($urandom());
      c.xl = 6'($urandom()); c.xr = 6'($urandom());
      c.yb = 6'($urandom()); c.yt = 6'($urandom());
    end else begin
      col = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 62) : $urandom_range(20, 23);
      row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 62) : $urandom_range(40, 43);
      c.col = col[5:0]; c.row = row[5:0];
      for (int i = 0; i < 4; i++) c.crn[i] = near_level();
      c.xl = col[5:0]; c.xr = 6'(col + 1); c.yb = row[5:0]; c.yt = 6'(row + 1);
    end
    return c;
  endfunction

  // push one cell beat and predict its links on acceptance
  task automatic send_cell(cell_t c);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, c.yt, c.yb, c.xr, c.xl, c.crn[3], c.crn[2], c.crn[1], c.crn[0],
                c.row, c.col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = predict_links(c);
    cells_sent++;
    if (c.no_link && n != 0) begin
      $error("cell %0d,%0d should give no links, predicted %0d", c.col, c.row, n);
      errors++;
    end
  endtask

  // let the block drain before touching configuration
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (link_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all five registers back to back
  task automatic load_levels(int cnt, int a, int b, int c, int d);
    int vals [5];
    vals = '{cnt, a, b, c, d};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i][15:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    lvl_count = cnt[2:0];
    lvl = '{a[15:0], b[15:0], c[15:0], d[15:0]};
    cfg_sets++;
  endtask

  // receiver stalls in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each link beat with the oldest prediction
  always @(posedge clk) begin
    link_t e;
    if (!rst && m_tvalid && m_tready) begin
      links_seen++;
      if (link_q.size() == 0) begin
        $error("unexpected link beat %h", m_tdata);
        errors++;
      end else begin
        e = link_q.pop_front();
        if (m_tuser != e.level) begin
          $error("level_index exp %0d got %0d", e.level, m_tuser); errors++;
        end
        if (m_tdata[5:0] != e.ocol) begin
          $error("origin_col exp %0d got %0d", e.ocol, m_tdata[5:0]); errors++;
        end
        if (m_tdata[11:6] != e.orow) begin
          $error("origin_row exp %0d got %0d", e.orow, m_tdata[11:6]); errors++;
        end
        if (m_tdata[17:12] != e.hcol) begin
          $error("head_col exp %0d got %0d", e.hcol, m_tdata[17:12]); errors++;
        end
        if (m_tdata[23:18] != e.hrow) begin
          $error("head_row exp %0d got %0d", e.hrow, m_tdata[23:18]); errors++;
        end
        if (m_tdata[29:24] != e.tcol) begin
          $error("tail_col exp %0d got %0d", e.tcol, m_tdata[29:24]); errors++;
        end
        if (m_tdata[35:30] != e.trow) begin
          $error("tail_row exp %0d got %0d", e.trow, m_tdata[35:30]); errors++;
        end
        if (m_tdata[36] != e.oslot) begin
          $error("out_second_slot exp %0d got %0d", e.oslot, m_tdata[36]); errors++;
        end
        if (m_tdata[37] != e.islot) begin
          $error("in_second_slot exp %0d got %0d", e.islot, m_tdata[37]); errors++;
        end
        if (m_tlast != e.last) begin
          $error("last exp %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d links outstanding", link_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cell_t dir_tab [$];
    int cnts [6];
    int levs [6][4];
    int n_items;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: one level at zero
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0));
    dir_tab.push_back(mk(5, 5, 5, 5, 5, 5, 5, 6, 5, 6, 1));
    dir_tab.push_back(mk(5, 5, -5, -5, -5, -5, 5, 6, 5, 6, 1));
    dir_tab.push_back(mk(62, 62, 32767, -32768, 32767, -32768, 62, 63, 62, 63, 0));
    dir_tab.push_back(mk(62, 62, -32768, 32767, -32768, 32767, 62, 63, 62, 63, 0));
    dir_tab.push_back(mk(10, 10, 100, -100, 100, -100, 10, 11, 10, 11, 0));
    dir_tab.push_back(mk(10, 10, 100, -100, 100, -100, 10, 11, 10, 11, 0));
    dir_tab.push_back(mk(11, 10, -100, 100, 100, -100, 11, 12, 10, 11, 0));
    dir_tab.push_back(mk(12, 3, 0, 40, 40, 40, 12, 13, 3, 4, 0));
    dir_tab.push_back(mk(12, 3, 0, -40, -40, -40, 12, 13, 3, 4, 0));
    dir_tab.push_back(mk(20, 30, 7, 0, -7, 0, 20, 21, 30, 31, 0));
    dir_tab.push_back(mk(0, 62, 32767, 32767, 32767, 0, 0, 1, 62, 63, 0));
    dir_tab.push_back(mk(62, 0, -1, 1, -1, 1, 63, 0, 63, 0, 0));
    dir_tab.push_back(mk(33, 17, 3, -9, 6, -2, 0, 63, 63, 0, 0));
    dir_tab.push_back(mk(1, 1, -32768, -32768, -32768, -32768, 1, 2, 1, 2, 1));
    dir_tab.push_back(mk(1, 1, 32767, 32767, 32767, 32767, 1, 2, 1, 2, 1));
    foreach (dir_tab[i]) send_cell(dir_tab[i]);
    drain();

    // four levels in ascending order around zero
    load_levels(4, -40, 0, 7, 100);
    dir_tab.delete();
    dir_tab.push_back(mk(10, 10, 100, -100, 100, -100, 10, 11, 10, 11, 0));
    dir_tab.push_back(mk(7, 7, -41, -50, -60, -70, 7, 8, 7, 8, 1));
    dir_tab.push_back(mk(7, 7, 101, 150, 160, 170, 7, 8, 7, 8, 1));
    dir_tab.push_back(mk(7, 7, -200, 200, -200, 200, 7, 8, 7, 8, 0));
    foreach (dir_tab[i]) send_cell(dir_tab[i]);
    drain();

    // random phases over several settings, extremes among them
    cnts = '{4, 2, 0, 7, 3, 1};
    levs = '{'{-1000, 0, 1000, 2000}, '{-32768, 32767, 0, 0},
             '{-5, 5, 10, 20}, '{-100, -50, 50, 100},
             '{300, -300, 0, 32767}, '{32767, -32768, -32768, 32767}};
    for (int p = 0; p < 6; p++) begin
      if (p == 4) begin
        for (int i = 0; i < 4; i++) levs[p][i] = int'($signed(16'($urandom())));
      end
      load_levels(cnts[p], levs[p][0], levs[p][1], levs[p][2], levs[p][3]);
      n_items = (p == 2) ? 20 : 65;
      if (p == 5) calm = 1'b1;
      for (int i = 0; i < n_items; i++) send_cell(rand_cell());
      drain();
    end

    $display("sent %0d cells over %0d level settings, checked %0d link beats",
             cells_sent, cfg_sets, links_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
